FILE: rtl/ptio_pkg.sv
// ----------------------------------------------------------------------------
// ptio_pkg
// Shared types and constants of the per-tenant io throttle: word formats of
// the request and result channels, register indexes and reset values.
// ----------------------------------------------------------------------------
package ptio_pkg;

  localparam int NUM_TENANTS_DEF = 16;
  localparam int MAX_DECAY_DEF   = 5;

  localparam int NUM_WIDTH = 64;   // divider dividend width
  localparam int DEN_WIDTH = 35;   // divider divisor width

  localparam logic [31:0] UTIL_SCALE = 32'd1000;

  localparam logic        RST_ENABLE     = 1'b1;
  localparam logic [15:0] RST_STEP       = 16'd5;
  localparam logic [15:0] RST_CEILING    = 16'd100;
  localparam logic [31:0] RST_INTERVAL   = 32'd100000;
  localparam logic [31:0] RST_TENANT_CYC = 32'd2000000;
  localparam logic [31:0] RST_SYSTEM_CYC = 32'd1000000;
  localparam logic [31:0] RST_RD_FLOOR   = 32'd1000;
  localparam logic [31:0] RST_WR_FLOOR   = 32'd10;

  typedef enum logic [3:0] {
    REG_ENABLE      = 4'd0,
    REG_STEP        = 4'd1,
    REG_CEILING     = 4'd2,
    REG_INTERVAL    = 4'd3,
    REG_TENANT_CYC  = 4'd4,
    REG_SYSTEM_CYC  = 4'd5,
    REG_RD_FLOOR    = 4'd6,
    REG_WR_FLOOR    = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REQ_LWRITE = 2'd0,
    REQ_LREAD  = 2'd1,
    REQ_PREAD  = 2'd2,
    REQ_PWRITE = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  tenant_id;
    logic [62:0] now_us;
    logic [31:0] latency_us;
  } in_t;

  typedef struct packed {
    logic [15:0] wait_us;
    logic        adjusted;
  } out_t;

endpackage

FILE: rtl/per_tenant_io_throttle.sv
// ----------------------------------------------------------------------------
// per_tenant_io_throttle
// Keeps decayed per-tenant io counts and system latency averages, and
// adjusts per-tenant delays against the mean utilisation.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_ready/in_data, one word each, and
// every request gives exactly one result word on out_valid/out_ready/out_data.
// Configuration writes go over cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high and writes should only be issued while the block is idle.
// One request is worked on at a time; in_ready is high only in the idle
// state, so the next word is taken once a result is loaded.
// The time from acceptance to result depends on the request type and on
// whether throttling is on. Each decay cycle that closes adds generation
// counting, and a closed latency cycle within range adds a division on
// the 64-bit serial divider. An adjust pass works out both latency
// averages (rolling them when the cycle closes), rolls and weighs the
// counts of each non-global tenant, takes the mean over the active
// tenants on the divider and then updates the delay of every tenant.
// Reset clears all counts, averages and delays (valid bits per tenant row)
// and loads the register defaults; no clearing sweep is needed.
// A finished result sits in an output register, so the next request is
// taken while the receiver stalls; a second result waits for the first.
// ----------------------------------------------------------------------------
module per_tenant_io_throttle
  import ptio_pkg::*;
#(
  parameter int NUM_TENANTS           = NUM_TENANTS_DEF,
  parameter int MAX_DECAY_GENERATIONS = MAX_DECAY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TW   = $clog2(NUM_TENANTS);
  localparam int GW   = $clog2(MAX_DECAY_GENERATIONS + 2);
  localparam int TOTW = 32 + TW;

  typedef struct packed {
    logic [2:0][62:0] st;
    logic [2:0][31:0] cn;
    logic [2:0][31:0] hi;
  } row_t;

  typedef enum logic [5:0] {
    S_IDLE, S_REQ_RD, S_ROW_LOAD, S_ROLL_CMP, S_ROLL_GEN, S_SLOT_END,
    S_LAT_END, S_LAT_DIV, S_REQ_CNT, S_REQ_WB, S_C_LAT, S_CHK_ADJ,
    S_P_LAT_AVG, S_P_LAT_DIV, S_P_LAT_FLOOR, S_T_START, S_T_R1, S_T_R2,
    S_T_WB, S_M0, S_M1, S_M2, S_M3, S_T_UTIL, S_T_NEXT, S_MEAN, S_MEAN_DIV,
    S_D_START, S_D_UPD, S_DLY_RD, S_DLY_WAIT, S_DLY_GET, S_FINISH
  } state_t;

  // configuration
  logic        en;
  logic [15:0] step;
  logic [15:0] ceiling;
  logic [31:0] interval;
  logic [31:0] tenant_cyc;
  logic [31:0] system_cyc;
  logic [31:0] rd_floor;
  logic [31:0] wr_floor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      en         <= RST_ENABLE;
      step       <= RST_STEP;
      ceiling    <= RST_CEILING;
      interval   <= RST_INTERVAL;
      tenant_cyc <= RST_TENANT_CYC;
      system_cyc <= RST_SYSTEM_CYC;
      rd_floor   <= RST_RD_FLOOR;
      wr_floor   <= RST_WR_FLOOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:     en         <= cfg_data[0];
        REG_STEP:       step       <= cfg_data[15:0];
        REG_CEILING:    ceiling    <= cfg_data[15:0];
        REG_INTERVAL:   interval   <= cfg_data;
        REG_TENANT_CYC: tenant_cyc <= cfg_data;
        REG_SYSTEM_CYC: system_cyc <= cfg_data;
        REG_RD_FLOOR:   rd_floor   <= cfg_data;
        REG_WR_FLOOR:   wr_floor   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and working registers
  state_t        state;
  state_t        ret;
  logic [1:0]    rtype;
  logic [TW-1:0] tid;
  logic          ok;
  logic [62:0]   now_r;
  logic [31:0]   lat_r;
  logic          adj;
  logic [15:0]   wait_r;
  logic          in_pass;
  logic          lmode;
  logic [1:0]    sk;
  logic          lk;
  logic          rolled;
  logic [62:0]   rem;
  logic [GW-1:0] gen;
  logic [TW-1:0] t;
  row_t          row;
  logic [31:0]   rv [3];
  logic [31:0]   lv [2];
  logic [31:0]   lv_tmp;
  logic [31:0]   util;
  logic [TOTW-1:0] total;
  logic [TOTW-1:0] mean;
  logic [TW-1:0] active;
  logic [62:0]   last_adj;

  logic [62:0]   lat_st  [2];
  logic [31:0]   lat_cnt [2];
  logic [63:0]   lat_sum [2];
  logic [63:0]   lat_avg [2];

  logic [NUM_TENANTS-1:0] rvld;
  logic [NUM_TENANTS-1:0] dvld;

  // memories
  row_t        row_mem  [NUM_TENANTS];
  logic [31:0] util_mem [NUM_TENANTS];
  logic [15:0] dly_mem  [NUM_TENANTS];
  row_t        row_q;
  logic [31:0] util_q;
  logic [15:0] dly_q;
  logic        row_we;
  logic        util_we;
  logic        dly_we;
  logic [15:0] dly_next;

  assign row_we  = (state == S_REQ_WB) || (state == S_T_WB);
  assign util_we = (state == S_T_UTIL);
  assign dly_we  = (state == S_D_UPD);

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[t] <= row;
    end
    if (util_we) begin
      util_mem[t] <= util;
    end
    if (dly_we) begin
      dly_mem[t] <= dly_next;
    end
    row_q  <= row_mem[t];
    util_q <= util_mem[t];
    dly_q  <= dly_mem[t];
  end

  // divider
  logic                 div_start;
  logic [NUM_WIDTH-1:0] div_num;
  logic [DEN_WIDTH-1:0] div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_q;

  ptio_div #(
    .NW (NUM_WIDTH),
    .DW (DEN_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  // shared datapath
  logic [62:0] cyc;
  logic [62:0] rs;
  logic [62:0] dlt;
  logic [31:0] cn_s;
  logic [31:0] hi_s;
  logic [31:0] base;
  logic [31:0] nh;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] mprod;
  logic [1:0]  req_slot;
  logic [15:0] d_cur;
  logic [16:0] d_sum;
  logic        act_gt1;

  always_comb begin
    if (lmode) begin
      cyc = (system_cyc == 32'd0) ? 63'd1 : 63'(system_cyc);
      rs  = lat_st[lk];
    end else begin
      cyc = (tenant_cyc == 32'd0) ? 63'd1 : 63'(tenant_cyc);
      rs  = row.st[sk];
    end
    dlt  = now_r - rs;
    cn_s = row.cn[sk];
    hi_s = row.hi[sk];
    base = (cn_s > 32'd1) ? cn_s : cn_s + (hi_s >> 1);
    nh   = (gen > GW'(MAX_DECAY_GENERATIONS)) ? 32'd0 : base >> (gen - GW'(1));
  end

  always_comb begin
    case (state)
      S_M0:    begin ma = rv[0]; mb = lv[0];      end
      S_M1:    begin ma = rv[1]; mb = lv[1];      end
      S_M2:    begin ma = rv[2]; mb = lv[1];      end
      default: begin ma = util;  mb = UTIL_SCALE; end
    endcase
    mprod = ma * mb;
  end

  assign req_slot = (rtype == REQ_LWRITE) ? 2'd2 : {1'b0, rtype[0]};

  always_comb begin
    d_cur   = dvld[t] ? dly_q : 16'd0;
    d_sum   = {1'b0, d_cur} + {1'b0, step};
    act_gt1 = active > TW'(1);
    dly_next = d_cur;
    if ((TOTW'(util_q) > mean) && (d_cur < ceiling) && act_gt1) begin
      dly_next = (d_sum < {1'b0, ceiling}) ? d_sum[15:0] : ceiling;
    end else if ((TOTW'(util_q) < mean) || !act_gt1) begin
      dly_next = (d_cur > step) ? d_cur - step : 16'd0;
    end
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
      in_pass   <= 1'b0;
      div_start <= 1'b0;
      rvld      <= '0;
      dvld      <= '0;
      last_adj  <= '0;
      for (int k = 0; k < 2; k++) begin
        lat_st[k]  <= '0;
        lat_cnt[k] <= '0;
        lat_sum[k] <= '0;
        lat_avg[k] <= '0;
      end
    end else begin
      div_start <= (state == S_LAT_END && gen <= GW'(MAX_DECAY_GENERATIONS)) ||
                   (state == S_P_LAT_AVG && !rolled) ||
                   (state == S_MEAN && active != '0);
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rtype  <= in_data.req_type;
            tid    <= TW'(in_data.tenant_id);
            t      <= TW'(in_data.tenant_id);
            ok     <= 32'(in_data.tenant_id) < 32'(NUM_TENANTS);
            now_r  <= in_data.now_us;
            lat_r  <= in_data.latency_us;
            adj    <= 1'b0;
            wait_r <= 16'd0;
            if (in_data.req_type == REQ_LWRITE || in_data.req_type == REQ_LREAD) begin
              if (in_data.req_type == REQ_LWRITE &&
                  32'(in_data.tenant_id) < 32'(NUM_TENANTS)) begin
                state <= S_REQ_RD;
              end else begin
                state <= S_CHK_ADJ;
              end
            end else if (en && 32'(in_data.tenant_id) < 32'(NUM_TENANTS)) begin
              state <= S_REQ_RD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_REQ_RD: state <= S_ROW_LOAD;
        S_ROW_LOAD: begin
          row   <= rvld[t] ? row_q : '0;
          lmode <= 1'b0;
          if (in_pass) begin
            sk  <= 2'd0;
            ret <= S_T_R1;
          end else begin
            sk  <= req_slot;
            ret <= S_REQ_CNT;
          end
          state <= S_ROLL_CMP;
        end
        S_ROLL_CMP: begin
          if (now_r < rs || dlt < cyc) begin
            // no cycle closed
            rolled <= 1'b0;
            if (now_r < rs) begin
              rv[sk] <= cn_s + (hi_s >> 1);
            end else if (dlt == 63'd0) begin
              rv[sk] <= hi_s;
            end else if (dlt < (cyc >> 1)) begin
              rv[sk] <= cn_s + (hi_s >> 1);
            end else begin
              rv[sk] <= cn_s;
            end
            state <= ret;
          end else begin
            rem   <= dlt - cyc;
            gen   <= GW'(1);
            state <= S_ROLL_GEN;
          end
        end
        S_ROLL_GEN: begin
          if (rem >= cyc && gen <= GW'(MAX_DECAY_GENERATIONS)) begin
            rem <= rem - cyc;
            gen <= gen + GW'(1);
          end else begin
            state <= lmode ? S_LAT_END : S_SLOT_END;
          end
        end
        S_SLOT_END: begin
          row.hi[sk] <= nh;
          row.st[sk] <= now_r;
          row.cn[sk] <= 32'd0;
          rv[sk]     <= nh;
          state      <= ret;
        end
        S_LAT_END: begin
          if (gen > GW'(MAX_DECAY_GENERATIONS)) begin
            lat_avg[lk] <= '0;
            lat_st[lk]  <= now_r;
            lat_cnt[lk] <= '0;
            lat_sum[lk] <= '0;
            rolled      <= 1'b1;
            state       <= ret;
          end else begin
            div_num   <= lat_avg[lk] + lat_sum[lk];
            div_den   <= DEN_WIDTH'(lat_cnt[lk]) + DEN_WIDTH'(1);
            state     <= S_LAT_DIV;
          end
        end
        S_LAT_DIV: begin
          if (div_done) begin
            lat_avg[lk] <= div_q >> (gen - GW'(1));
            lat_st[lk]  <= now_r;
            lat_cnt[lk] <= '0;
            lat_sum[lk] <= '0;
            rolled      <= 1'b1;
            state       <= ret;
          end
        end
        S_REQ_CNT: begin
          row.cn[sk] <= row.cn[sk] + 32'd1;
          state      <= S_REQ_WB;
        end
        S_REQ_WB: begin
          rvld[t] <= 1'b1;
          if (rtype == REQ_LWRITE) begin
            state <= S_CHK_ADJ;
          end else begin
            lk    <= rtype[0];
            lmode <= 1'b1;
            ret   <= S_C_LAT;
            state <= S_ROLL_CMP;
          end
        end
        S_C_LAT: begin
          lat_cnt[lk] <= lat_cnt[lk] + 32'd1;
          lat_sum[lk] <= lat_sum[lk] + 64'(lat_r);
          state       <= S_FINISH;
        end
        S_CHK_ADJ: begin
          if (en && now_r > last_adj && (now_r - last_adj) > 63'(interval)) begin
            last_adj <= now_r;
            adj      <= 1'b1;
            in_pass  <= 1'b1;
            total    <= '0;
            active   <= '0;
            lk       <= 1'b0;
            lmode    <= 1'b1;
            ret      <= S_P_LAT_AVG;
            state    <= S_ROLL_CMP;
          end else begin
            state <= S_DLY_RD;
          end
        end
        S_P_LAT_AVG: begin
          if (rolled) begin
            lv_tmp <= lat_avg[lk][31:0];
            state  <= S_P_LAT_FLOOR;
          end else begin
            div_num   <= lat_avg[lk] + {lat_sum[lk][60:0], 3'b000};
            div_den   <= {lat_cnt[lk], 3'b000} + DEN_WIDTH'(1);
            state     <= S_P_LAT_DIV;
          end
        end
        S_P_LAT_DIV: begin
          if (div_done) begin
            lv_tmp <= div_q[31:0];
            state  <= S_P_LAT_FLOOR;
          end
        end
        S_P_LAT_FLOOR: begin
          if (lv_tmp == 32'd0) begin
            lv[lk] <= lk ? wr_floor : rd_floor;
          end else begin
            lv[lk] <= lv_tmp;
          end
          if (!lk) begin
            lk    <= 1'b1;
            ret   <= S_P_LAT_AVG;
            state <= S_ROLL_CMP;
          end else begin
            t     <= '0;
            state <= S_T_START;
          end
        end
        S_T_START: begin
          // global tenant has no utilisation
          if (t == '0) begin
            util  <= 32'd0;
            state <= S_T_UTIL;
          end else begin
            state <= S_ROW_LOAD;
          end
        end
        S_T_R1: begin
          sk    <= 2'd1;
          ret   <= S_T_R2;
          state <= S_ROLL_CMP;
        end
        S_T_R2: begin
          sk    <= 2'd2;
          ret   <= S_T_WB;
          state <= S_ROLL_CMP;
        end
        S_T_WB: begin
          rvld[t] <= 1'b1;
          if ((rv[0] | rv[1] | rv[2]) == 32'd0) begin
            util  <= 32'd0;
            state <= S_T_UTIL;
          end else begin
            state <= S_M0;
          end
        end
        S_M0: begin
          util  <= mprod[31:0];
          state <= S_M1;
        end
        S_M1: begin
          util  <= util + mprod[31:0];
          state <= S_M2;
        end
        S_M2: begin
          util  <= util + mprod[31:0];
          state <= S_M3;
        end
        S_M3: begin
          util  <= mprod[31:0];
          state <= S_T_UTIL;
        end
        S_T_UTIL: begin
          total <= total + TOTW'(util);
          if (util != 32'd0) begin
            active <= active + TW'(1);
          end
          state <= S_T_NEXT;
        end
        S_T_NEXT: begin
          if (t == TW'(NUM_TENANTS - 1)) begin
            state <= S_MEAN;
          end else begin
            t     <= t + TW'(1);
            state <= S_T_START;
          end
        end
        S_MEAN: begin
          t <= '0;
          if (active != '0) begin
            div_num   <= NUM_WIDTH'(total);
            div_den   <= DEN_WIDTH'(active);
            state     <= S_MEAN_DIV;
          end else begin
            mean  <= '0;
            state <= S_D_START;
          end
        end
        S_MEAN_DIV: begin
          if (div_done) begin
            mean  <= div_q[TOTW-1:0];
            state <= S_D_START;
          end
        end
        S_D_START: state <= S_D_UPD;
        S_D_UPD: begin
          dvld[t] <= 1'b1;
          if (t == TW'(NUM_TENANTS - 1)) begin
            in_pass <= 1'b0;
            state   <= S_DLY_RD;
          end else begin
            t     <= t + TW'(1);
            state <= S_D_START;
          end
        end
        S_DLY_RD: begin
          if (en && ok) begin
            t     <= tid;
            state <= S_DLY_WAIT;
          end else begin
            wait_r <= 16'd0;
            state  <= S_FINISH;
          end
        end
        S_DLY_WAIT: state <= S_DLY_GET;
        S_DLY_GET: begin
          wait_r <= dvld[t] ? dly_q : 16'd0;
          state  <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            out_data.wait_us  <= wait_r;
            out_data.adjusted <= adj;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_gen_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROLL_GEN) |-> (gen >= GW'(1) &&
                               gen <= GW'(MAX_DECAY_GENERATIONS + 1)))
    else $error("decay generation count out of range");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_LAT_DIV || state == S_P_LAT_DIV ||
                  state == S_MEAN_DIV))
    else $error("quotient arrived with no division pending");

  a_pass_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !in_pass)
    else $error("ready raised during an adjust pass");

endmodule

FILE: rtl/ptio_div.sv
// ----------------------------------------------------------------------------
// ptio_div
// Restoring divider, one quotient bit per cycle. Operands are taken on
// start, done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module ptio_div
  import ptio_pkg::*;
#(
  parameter int NW = NUM_WIDTH,
  parameter int DW = DEN_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        if (diff[DW]) begin
          rem <= trial[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end else begin
          rem <= diff[DW-1:0];
          quo <= {quo[NW-2:0], 1'b1};
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for per_tenant_io_throttle. A directed table runs first
// under the reset register values. Random phases follow, each under its own
// register setting. Every request word is pushed through an in-bench model
// of the tenant counts, the latency averages and the delay adjust pass. Each
// result word is then compared with the oldest expected word.
// ----------------------------------------------------------------------------
module testbench
  import ptio_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TENANTS    = 16;
  localparam int SLOTS      = TENANTS * 3;
  localparam int MAX_GEN    = 5;
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_WORDS = 225;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;

  per_tenant_io_throttle DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    in_t  word;
    bit   fixed;
    out_t res;
  } row_t;

  typedef struct {
    bit   fixed;
    out_t res;
  } tag_t;

  // shadow registers
  logic        sh_enable;
  logic [31:0] sh_step, sh_ceiling, sh_interval, sh_tcyc, sh_scyc, sh_rfloor, sh_wfloor;

  // shadow state
  logic [63:0] cnt_start [SLOTS];
  logic [31:0] cnt_cur   [SLOTS];
  logic [31:0] cnt_hist  [SLOTS];
  logic [31:0] util      [TENANTS];
  logic [15:0] dly       [TENANTS];
  logic [63:0] lat_start [2];
  logic [31:0] lat_cnt   [2];
  logic [63:0] lat_sum   [2];
  logic [63:0] lat_avg   [2];
  logic [63:0] last_adj;

  out_t pending_results[$];
  tag_t fixed_tags[$];
  row_t directed[$];

  int   errors;
  int   results_seen;
  int   idle_cycles;
  bit   calm;
  bit   held;
  int   rx_stall;
  logic [63:0] cur_time;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic void set_reg(logic [3:0] idx, logic [31:0] v);
    case (cfg_reg_e'(idx))
      REG_ENABLE:     sh_enable   = v[0];
      REG_STEP:       sh_step     = {16'd0, v[15:0]};
      REG_CEILING:    sh_ceiling  = {16'd0, v[15:0]};
      REG_INTERVAL:   sh_interval = v;
      REG_TENANT_CYC: sh_tcyc     = v;
      REG_SYSTEM_CYC: sh_scyc     = v;
      REG_RD_FLOOR:   sh_rfloor   = v;
      REG_WR_FLOOR:   sh_wfloor   = v;
      default: ;
    endcase
  endfunction

  // 0: history, 1: early in cycle, 2: late in cycle
  function automatic int roll_slot(logic [63:0] now, int s);
    logic [63:0] cyc, d, gen;
    logic [31:0] h;
    cyc = (sh_tcyc == 0) ? 64'd1 : {32'd0, sh_tcyc};
    if (now < cnt_start[s]) return 1;
    d = now - cnt_start[s];
    if (d < cyc) begin
      if (d == 0) return 0;
      return (d < cyc / 2) ? 1 : 2;
    end
    gen = d / cyc;
    if (gen > MAX_GEN) begin
      cnt_hist[s] = 0;
    end else begin
      h = (cnt_cur[s] > 1) ? cnt_cur[s] : cnt_cur[s] + (cnt_hist[s] >> 1);
      for (int i = 1; i < gen; i++) h = h >> 1;
      cnt_hist[s] = h;
    end
    cnt_start[s] = now;
    cnt_cur[s] = 0;
    return 0;
  endfunction

  function automatic logic [31:0] slot_count(logic [63:0] now, int s);
    int r;
    r = roll_slot(now, s);
    if (r == 0) return cnt_hist[s];
    if (r == 1) return cnt_cur[s] + (cnt_hist[s] >> 1);
    return cnt_cur[s];
  endfunction

  function automatic bit roll_latency(logic [63:0] now, int k);
    logic [63:0] cyc, d, gen, a;
    cyc = (sh_scyc == 0) ? 64'd1 : {32'd0, sh_scyc};
    if (now < lat_start[k]) return 0;
    d = now - lat_start[k];
    if (d < cyc) return 0;
    gen = d / cyc;
    if (gen > MAX_GEN) begin
      lat_avg[k] = 0;
    end else begin
      a = (lat_avg[k] + lat_sum[k]) / (64'd1 + {32'd0, lat_cnt[k]});
      for (int i = 1; i < gen; i++) a = a >> 1;
      lat_avg[k] = a;
    end
    lat_start[k] = now;
    lat_cnt[k] = 0;
    lat_sum[k] = 0;
    return 1;
  endfunction

  function automatic logic [31:0] mean_latency(logic [63:0] now, int k);
    logic [63:0] q;
    logic [31:0] v;
    if (roll_latency(now, k)) begin
      v = lat_avg[k][31:0];
    end else begin
      q = (lat_avg[k] + lat_sum[k] * 64'd8) / (64'd1 + {32'd0, lat_cnt[k]} * 64'd8);
      v = q[31:0];
    end
    if (v == 0) v = k ? sh_wfloor : sh_rfloor;
    return v;
  endfunction

  function automatic void adjust_delays(logic [63:0] now);
    logic [31:0] rl, wl, r, w, lw, d;
    logic [63:0] total, mean, u;
    int active;
    rl = mean_latency(now, 0);
    wl = mean_latency(now, 1);
    total = 0;
    mean = 0;
    active = 0;
    for (int t = 0; t < TENANTS; t++) begin
      util[t] = 0;
      if (t != 0) begin
        r  = slot_count(now, t * 3);
        w  = slot_count(now, t * 3 + 1);
        lw = slot_count(now, t * 3 + 2);
        if ((r | w | lw) != 0) begin
          util[t] = (r * rl + w * wl + lw * wl) * 32'd1000;
          total += {32'd0, util[t]};
          if (util[t] > 0) active++;
        end
      end
    end
    if (active > 0) mean = total / active;
    for (int t = 0; t < TENANTS; t++) begin
      d = {16'd0, dly[t]};
      u = {32'd0, util[t]};
      if (u > mean && d < sh_ceiling && active > 1) begin
        d = (d + sh_step < sh_ceiling) ? d + sh_step : sh_ceiling;
      end else if (u < mean || active <= 1) begin
        d = (d > sh_step) ? d - sh_step : 32'd0;
      end
      dly[t] = d[15:0];
    end
  endfunction

  function automatic out_t predict_wait(in_t w);
    out_t o;
    logic [63:0] now;
    int t, k;
    o = '0;
    now = {1'b0, w.now_us};
    t = w.tenant_id;
    if (w.req_type == REQ_LWRITE || w.req_type == REQ_LREAD) begin
      if (w.req_type == REQ_LWRITE) begin
        void'(roll_slot(now, t * 3 + 2));
        cnt_cur[t * 3 + 2]++;
      end
      if (sh_enable) begin
        if (now > last_adj && now - last_adj > {32'd0, sh_interval}) begin
          last_adj = now;
          adjust_delays(now);
          o.adjusted = 1'b1;
        end
        o.wait_us = dly[t];
      end
    end else if (sh_enable) begin
      k = (w.req_type == REQ_PREAD) ? 0 : 1;
      void'(roll_slot(now, t * 3 + k));
      cnt_cur[t * 3 + k]++;
      void'(roll_latency(now, k));
      lat_cnt[k]++;
      lat_sum[k] += {32'd0, w.latency_us};
    end
    return o;
  endfunction

  function automatic void clear_model();
    for (int s = 0; s < SLOTS; s++) begin
      cnt_start[s] = 0;
      cnt_cur[s] = 0;
      cnt_hist[s] = 0;
    end
    for (int t = 0; t < TENANTS; t++) begin
      util[t] = 0;
      dly[t] = 0;
    end
    for (int k = 0; k < 2; k++) begin
      lat_start[k] = 0;
      lat_cnt[k] = 0;
      lat_sum[k] = 0;
      lat_avg[k] = 0;
    end
    last_adj = 0;
    sh_enable = RST_ENABLE;
    sh_step = {16'd0, RST_STEP};
    sh_ceiling = {16'd0, RST_CEILING};
    sh_interval = RST_INTERVAL;
    sh_tcyc = RST_TENANT_CYC;
    sh_scyc = RST_SYSTEM_CYC;
    sh_rfloor = RST_RD_FLOOR;
    sh_wfloor = RST_WR_FLOOR;
  endfunction

  // monitor: prediction on request words, checking on result words
  always @(posedge clk) begin
    out_t want;
    tag_t tag;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report("unexpected result word", out_data, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.wait_us !== want.wait_us)
            report("wait_us", out_data.wait_us, want.wait_us);
          if (out_data.adjusted !== want.adjusted)
            report("adjusted", out_data.adjusted, want.adjusted);
        end
      end
      if (cfg_valid && cfg_ready) set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        want = predict_wait(in_data);
        tag = fixed_tags.pop_front();
        if (tag.fixed) want = tag.res;
        pending_results.push_back(want);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 300) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (250) @(negedge clk);
        out_ready <= 1'b1;
      end else if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(in_t w, bit fixed, out_t res);
    tag_t tag;
    tag.fixed = fixed;
    tag.res = res;
    fixed_tags.push_back(tag);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic row_t mk(req_type_e rt, int tid, logic [62:0] now, logic [31:0] lat,
                              bit fixed, logic [15:0] w, logic a);
    row_t r;
    r.word.req_type = rt;
    r.word.tenant_id = tid[3:0];
    r.word.now_us = now;
    r.word.latency_us = lat;
    r.fixed = fixed;
    r.res.wait_us = w;
    r.res.adjusted = a;
    return r;
  endfunction

  function automatic logic [62:0] next_time(logic [63:0] scale);
    int pick;
    logic [63:0] back;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      back = cur_time - 64'($urandom_range(0, scale[31:0]));
      return back[62:0];
    end
    if (pick == 1) cur_time += scale * $urandom_range(2, 12);
    else cur_time += $urandom_range(0, scale[31:0] / 8 + 1);
    return cur_time[62:0];
  endfunction

  function automatic in_t random_word(logic [63:0] scale);
    in_t w;
    w.req_type = req_type_e'($urandom_range(0, 3));
    w.tenant_id = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 5));
    w.now_us = next_time(scale);
    w.latency_us = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
    return w;
  endfunction

  initial begin
    logic [31:0] regs [6][8];
    logic [63:0] scales [6];
    logic [63:0] wide;
    in_t w;
    row_t r;

    regs[0] = '{1, 5, 100, 100000, 2000000, 1000000, 1000, 10};
    regs[1] = '{1, 1, 65535, 0, 0, 0, 0, 0};
    regs[2] = '{1, 65535, 65535, 1000, 5000, 3000, 32'hffffffff, 32'hffffffff};
    regs[3] = '{0, 3, 50, 200, 4000, 3000, 500, 50};
    regs[4] = '{1, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1};
    regs[5] = '{1, 7, 40, 500, 3000, 2000, 300, 20};
    scales = '{60000, 8, 2000, 5000, 1000000, 1500};

    errors = 0;
    results_seen = 0;
    idle_cycles = 0;
    calm = 0;
    held = 0;
    rx_stall = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    clear_model();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows under reset register values
    directed.push_back(mk(REQ_LREAD,  0, 0,  0, 1, 0, 0));
    directed.push_back(mk(REQ_LWRITE, 1, 10, 0, 1, 0, 0));
    directed.push_back(mk(REQ_PREAD,  1, 20, 32'hffffffff, 1, 0, 0));
    directed.push_back(mk(REQ_PWRITE, 15, 30, 0, 1, 0, 0));
    directed.push_back(mk(REQ_PREAD,  2, 40, 500, 0, 0, 0));
    directed.push_back(mk(REQ_PWRITE, 2, 50, 7, 0, 0, 0));
    directed.push_back(mk(REQ_LWRITE, 3, 60, 0, 0, 0, 0));
    directed.push_back(mk(REQ_LREAD,  1, 200000, 0, 0, 0, 0));
    directed.push_back(mk(REQ_LREAD,  2, 200001, 0, 0, 0, 0));
    directed.push_back(mk(REQ_LWRITE, 0, 300001, 0, 0, 0, 0));
    // time going backwards
    directed.push_back(mk(REQ_PREAD,  1, 150000, 900, 0, 0, 0));
    directed.push_back(mk(REQ_LREAD,  15, 150000, 0, 0, 0, 0));
    directed.push_back(mk(REQ_PREAD,  1, 2500000, 1200, 0, 0, 0));
    // gap beyond the decay generations
    directed.push_back(mk(REQ_LREAD,  1, 20000000, 0, 0, 0, 0));
    directed.push_back(mk(REQ_PWRITE, 4, 20000010, 32'hffffffff, 0, 0, 0));
    directed.push_back(mk(REQ_LWRITE, 15, 20500000, 0, 0, 0, 0));
    directed.push_back(mk(REQ_LREAD,  2, 21000000, 0, 0, 0, 0));
    foreach (directed[i]) send_word(directed[i].word, directed[i].fixed, directed[i].res);
    cur_time = 21000000;

    for (int p = 0; p < 6; p++) begin
      // sender pauses until every expected word is back
      drain();
      for (int i = 0; i < 8; i++) cfg_write(cfg_reg_e'(i), regs[p][i]);
      if (p == 5) calm = 1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w = random_word(scales[p]);
        send_word(w, 0, '0);
      end
    end

    // top bits of the time field, including its largest value
    for (int n = 0; n < 20; n++) begin
      w = random_word(1);
      wide = {$urandom, $urandom};
      w.now_us = wide[62:0];
      send_word(w, 0, '0);
    end
    w = random_word(1);
    w.now_us = '1;
    send_word(w, 0, '0);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
